[sv/tsb_pkg.sv]
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants for triangle sub-cell binning.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int SUB_DIVISIONS_DEF = 4;

  localparam int COORD_W   = 32;
  localparam int CHUNK_W   = 16;
  localparam int TRI_W     = 16;
  localparam int SIZE_W    = 16;
  localparam int OUT_IDX_W = 2;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;

  // default edge length 1.5 in 8.8 fixed point
  localparam logic [SIZE_W-1:0] SUB_CELL_SIZE_RST = 16'd384;

  // register byte addresses
  localparam logic [CFG_AW-1:0] ADDR_SUB_CELL_SIZE = 2'd0;

  // subtractor width used by the default configuration
  localparam int ALU_W_DEF = 38;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic signed [CHUNK_W-1:0] chunk_x;
    logic signed [CHUNK_W-1:0] chunk_y;
    logic signed [CHUNK_W-1:0] chunk_z;
    logic [TRI_W-1:0]          triangle_id;
    logic                      final_vertex;
  } in_t;

  typedef struct packed {
    logic [TRI_W-1:0]     tri_out;
    logic [OUT_IDX_W-1:0] sub_x;
    logic [OUT_IDX_W-1:0] sub_y;
    logic [OUT_IDX_W-1:0] sub_z;
    logic                 last_cell;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ORIGIN,
    ST_DIFF,
    ST_STEP,
    ST_EMIT
  } state_t;

endpackage

[sv/tsb_alu.sv]
// ----------------------------------------------------------------------------
// tsb_alu
// Shared signed subtractor: bound minus origin, then offset minus
// running multiple of the sub-cell size for the index search.
// ----------------------------------------------------------------------------
module tsb_alu #(
  parameter int ALU_W = tsb_pkg::ALU_W_DEF
) (
  input  logic signed [ALU_W-1:0] op_a,
  input  logic signed [ALU_W-1:0] op_b,
  output logic signed [ALU_W-1:0] diff,
  output logic                    a_ge_b
);

  assign diff   = op_a - op_b;
  assign a_ge_b = ~diff[ALU_W-1];

endmodule

[sv/triangle_subcell_binning.sv]
// ----------------------------------------------------------------------------
// triangle_subcell_binning
// Bins a triangle's bounding box into the sub-cells of its chunk.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one vertex per item. Non-final vertices fold into the running
//           min/max. The item with final_vertex set closes the triangle
//           and starts the index search.
//   out_* : one item per covered sub-cell, x outermost, z innermost;
//           last_cell marks the final one of the triangle.
//   cfg_* : APB-style port, sub_cell_size at byte address 0 (0 acts as 1).
// Sequence:
//   each axis starts with an origin multiply step; each of the six bounds
//   then takes a subtract step, then compare steps on the shared subtractor
//   until the index is found. Emission then gives one sub-cell per cycle
//   while out_ready is high. in_ready is low until the last sub-cell sits
//   in the output register.
// Reset: sequencer idle, no partial triangle, sub_cell_size = 1.5.
// Stall: a held output item freezes the emission counters; nothing is lost.
// ----------------------------------------------------------------------------
module triangle_subcell_binning #(
  parameter int SUB_DIVISIONS = tsb_pkg::SUB_DIVISIONS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tsb_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tsb_pkg::out_t               out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tsb_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tsb_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tsb_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int COORD_W = tsb_pkg::COORD_W;
  localparam int CHUNK_W = tsb_pkg::CHUNK_W;
  localparam int SIZE_W  = tsb_pkg::SIZE_W;
  localparam int OIW     = tsb_pkg::OUT_IDX_W;

  // index widths
  localparam int IDX_W  = (SUB_DIVISIONS > 1) ? $clog2(SUB_DIVISIONS) : 1;
  localparam int CELL_W = (IDX_W > OIW) ? IDX_W : OIW;
  // chunk * S, then * size, then bound - origin
  localparam int SW     = $clog2(SUB_DIVISIONS + 1);
  localparam int CS_W   = CHUNK_W + SW + 1;
  localparam int ORIG_W = CS_W + SIZE_W + 1;
  localparam int D_W    = ORIG_W + 1;
  // running multiple (k+1)*size, at most S*size
  localparam int ACC_W  = SIZE_W + SW;

  localparam logic [CELL_W-1:0]      MAX_IDX  = CELL_W'(SUB_DIVISIONS - 1);
  localparam logic signed [CS_W-1:0] SUBDIV_S = CS_W'(SUB_DIVISIONS);

  // ---------------------------------------------------------------- state
  tsb_pkg::state_t state_r, state_nxt;

  logic [1:0]                seen_r, seen_nxt;          // vertices so far, sat. 3
  logic signed [COORD_W-1:0] min_r [3];
  logic signed [COORD_W-1:0] max_r [3];
  logic signed [COORD_W-1:0] min_nxt [3];
  logic signed [COORD_W-1:0] max_nxt [3];
  logic signed [CHUNK_W-1:0] chunk_r [3];
  logic [tsb_pkg::TRI_W-1:0] tri_r;
  logic [SIZE_W-1:0]         size_r, size_nxt;

  logic [1:0]                axis_r, axis_nxt;          // axis under search
  logic                      side_r, side_nxt;          // 0: min bound, 1: max
  logic signed [ORIG_W-1:0]  origin_r, origin_nxt;
  logic signed [D_W-1:0]     d_r, d_nxt;                // bound - origin
  logic [ACC_W-1:0]          acc_r, acc_nxt;            // (k+1)*size
  logic [CELL_W-1:0]         k_r, k_nxt;                // candidate index
  logic [CELL_W-1:0]         lo_r [3];
  logic [CELL_W-1:0]         hi_r [3];
  logic [CELL_W-1:0]         cx_r, cy_r, cz_r;
  logic [CELL_W-1:0]         cx_nxt, cy_nxt, cz_nxt;

  logic                      out_valid_r, out_valid_nxt;
  tsb_pkg::out_t             out_data_r, out_data_nxt;

  // ---------------------------------------------------------------- misc
  logic                      in_fire;
  logic                      cfg_we;
  logic [SIZE_W-1:0]         size_eff;
  logic signed [COORD_W-1:0] vtx [3];
  logic signed [CHUNK_W-1:0] chunk_sel;
  logic signed [CS_W-1:0]    chunk_s;
  logic signed [ORIG_W-1:0]  origin_prod;
  logic signed [COORD_W-1:0] bound_sel;
  logic signed [D_W-1:0]     alu_a, alu_b, alu_diff;
  logic                      alu_ge;
  logic                      step_more;
  logic                      emit_load;
  logic                      cell_last;

  assign in_ready  = (state_r == tsb_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == tsb_pkg::ADDR_SUB_CELL_SIZE);
  assign size_nxt   = cfg_we ? cfg_pwdata[SIZE_W-1:0] : size_r;
  assign cfg_prdata = (cfg_paddr == tsb_pkg::ADDR_SUB_CELL_SIZE) ?
                      {{(tsb_pkg::CFG_DW-SIZE_W){1'b0}}, size_r} : '0;
  assign size_eff   = (size_r == '0) ? SIZE_W'(1) : size_r;

  // ---------------------------------------------------------------- bounds
  assign vtx[0] = in_data.vertex_x;
  assign vtx[1] = in_data.vertex_y;
  assign vtx[2] = in_data.vertex_z;

  // first vertex loads, later ones merge
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      min_nxt[a] = min_r[a];
      max_nxt[a] = max_r[a];
      if (in_fire) begin
        if (seen_r == 2'd0 || vtx[a] < min_r[a]) min_nxt[a] = vtx[a];
        if (seen_r == 2'd0 || vtx[a] > max_r[a]) max_nxt[a] = vtx[a];
      end
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (in_fire) begin
      if (in_data.final_vertex) begin
        seen_nxt = 2'd0;
      end else if (seen_r != 2'd3) begin
        seen_nxt = seen_r + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  // origin = chunk * S * size; small constant multiply then one 20x17 multiply
  assign chunk_sel   = chunk_r[axis_r];
  assign chunk_s     = CS_W'(chunk_sel) * SUBDIV_S;
  assign origin_prod = chunk_s * $signed({1'b0, size_eff});

  assign bound_sel = side_r ? max_r[axis_r] : min_r[axis_r];

  // shared subtractor: offset in DIFF, offset vs. next multiple in STEP
  always_comb begin
    if (state_r == tsb_pkg::ST_STEP) begin
      alu_a = d_r;
      alu_b = D_W'($signed({1'b0, acc_r}));
    end else begin
      alu_a = D_W'(bound_sel);
      alu_b = D_W'(origin_r);
    end
  end

  tsb_alu #(
    .ALU_W (D_W)
  ) u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .diff   (alu_diff),
    .a_ge_b (alu_ge)
  );

  // negative offsets never pass the first compare, so they settle at 0
  assign step_more = (k_r != MAX_IDX) && alu_ge;

  assign emit_load = !out_valid_r || out_ready;
  assign cell_last = (cx_r == hi_r[0]) && (cy_r == hi_r[1]) && (cz_r == hi_r[2]);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsb_pkg::ST_IDLE: begin
        if (in_fire && in_data.final_vertex) state_nxt = tsb_pkg::ST_ORIGIN;
      end
      tsb_pkg::ST_ORIGIN: begin
        state_nxt = tsb_pkg::ST_DIFF;
      end
      tsb_pkg::ST_DIFF: begin
        state_nxt = tsb_pkg::ST_STEP;
      end
      tsb_pkg::ST_STEP: begin
        if (!step_more) begin
          if (!side_r)              state_nxt = tsb_pkg::ST_DIFF;
          else if (axis_r == 2'd2)  state_nxt = tsb_pkg::ST_EMIT;
          else                      state_nxt = tsb_pkg::ST_ORIGIN;
        end
      end
      tsb_pkg::ST_EMIT: begin
        if (emit_load && cell_last) state_nxt = tsb_pkg::ST_IDLE;
      end
      default: state_nxt = tsb_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    axis_nxt      = axis_r;
    side_nxt      = side_r;
    origin_nxt    = origin_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      tsb_pkg::ST_IDLE: begin
        axis_nxt = 2'd0;
        side_nxt = 1'b0;
      end
      tsb_pkg::ST_ORIGIN: begin
        origin_nxt = origin_prod;
        side_nxt   = 1'b0;
      end
      tsb_pkg::ST_DIFF: begin
        d_nxt   = alu_diff;
        acc_nxt = ACC_W'(size_eff);
        k_nxt   = '0;
      end
      tsb_pkg::ST_STEP: begin
        if (step_more) begin
          k_nxt   = k_r + CELL_W'(1);
          acc_nxt = acc_r + ACC_W'(size_eff);
        end else if (!side_r) begin
          side_nxt = 1'b1;
        end else if (axis_r == 2'd2) begin
          cx_nxt = lo_r[0];
          cy_nxt = lo_r[1];
          cz_nxt = lo_r[2];
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      tsb_pkg::ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.tri_out   = tri_r;
          out_data_nxt.sub_x     = cx_r[OIW-1:0];
          out_data_nxt.sub_y     = cy_r[OIW-1:0];
          out_data_nxt.sub_z     = cz_r[OIW-1:0];
          out_data_nxt.last_cell = cell_last;
          // z innermost, x outermost
          if (cz_r != hi_r[2]) begin
            cz_nxt = cz_r + CELL_W'(1);
          end else begin
            cz_nxt = lo_r[2];
            if (cy_r != hi_r[1]) begin
              cy_nxt = cy_r + CELL_W'(1);
            end else begin
              cy_nxt = lo_r[1];
              cx_nxt = cx_r + CELL_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsb_pkg::ST_IDLE;
      seen_r      <= 2'd0;
      size_r      <= tsb_pkg::SUB_CELL_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      min_r[a] <= min_nxt[a];
      max_r[a] <= max_nxt[a];
    end
    if (in_fire && in_data.final_vertex) begin
      chunk_r[0] <= in_data.chunk_x;
      chunk_r[1] <= in_data.chunk_y;
      chunk_r[2] <= in_data.chunk_z;
      tri_r      <= in_data.triangle_id;
    end
    if (state_r == tsb_pkg::ST_STEP && !step_more) begin
      if (side_r) hi_r[axis_r] <= k_r;
      else        lo_r[axis_r] <= k_r;
    end
    axis_r     <= axis_nxt;
    side_r     <= side_nxt;
    origin_r   <= origin_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
  // a closing vertex always hands control to the sequencer
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.final_vertex) |=> !in_ready)
    else $error("input still ready after final vertex");

  // min bound never maps above max bound
  a_lo_le_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsb_pkg::ST_EMIT) |->
      (lo_r[0] <= hi_r[0]) && (lo_r[1] <= hi_r[1]) && (lo_r[2] <= hi_r[2]))
    else $error("sub-cell range inverted");

  // emission walk stays inside the range
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsb_pkg::ST_EMIT) |->
      (cx_r >= lo_r[0]) && (cx_r <= hi_r[0]) &&
      (cy_r >= lo_r[1]) && (cy_r <= hi_r[1]) &&
      (cz_r >= lo_r[2]) && (cz_r <= hi_r[2]))
    else $error("emission counter left the sub-cell range");

  // index search never passes the last sub-cell
  a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsb_pkg::ST_STEP) |-> (k_r <= MAX_IDX))
    else $error("index search overran");
`endif

endmodule

[tb/triangle_subcell_binning_tb.sv]
// ----------------------------------------------------------------------------
// triangle_subcell_binning_tb
// Self-checking bench for triangle sub-cell binning.
// ----------------------------------------------------------------------------
// Vertex items go in over a valid/ready channel. A built-in predictor keeps
// its own running bounding box and sub-cell size, and queues the sub-cells
// that each closing vertex should produce. Every sub-cell that comes out is
// compared field by field with the oldest queued one. A directed pass covers
// full-chunk and single-cell triangles, short and long triangles, far bounds
// and the size extremes. Randomized phases then run at several sizes, with
// idle bursts on both sides except in the final phase.
// ----------------------------------------------------------------------------
module triangle_subcell_binning_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = tsb_pkg::COORD_W;
  localparam int CHUNK_W   = tsb_pkg::CHUNK_W;
  localparam int TRI_W     = tsb_pkg::TRI_W;
  localparam int SIZE_W    = tsb_pkg::SIZE_W;
  localparam int OUT_IDX_W = tsb_pkg::OUT_IDX_W;
  localparam int CFG_AW    = tsb_pkg::CFG_AW;
  localparam int CFG_DW    = tsb_pkg::CFG_DW;

  localparam int SUBDIV        = tsb_pkg::SUB_DIVISIONS_DEF;
  localparam int LATENCY_MAX   = 40;
  localparam int DRAIN_LIMIT   = 5000;   // cycles to wait for queued sub-cells
  localparam int PRINT_LIMIT   = 50;

  // --------------------------------------------------------------------------
  // DUT hookup, every input known from time zero
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  tsb_pkg::in_t      in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  tsb_pkg::out_t     out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  triangle_subcell_binning DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: own copy of the bounding box and the size register
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] box_lo [3];
  logic signed [COORD_W-1:0] box_hi [3];
  int                        verts_taken = 0;          // saturates at 3
  logic [SIZE_W-1:0]         cell_size   = tsb_pkg::SUB_CELL_SIZE_RST;

  tsb_pkg::out_t pending_cells [$];   // sub-cells still owed by the DUT, oldest first

  int errors        = 0;
  int vertices_sent = 0;
  bit idle_on       = 1'b1;  // random gaps on both channels
  int stall_left    = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // floor((bound - origin) / step), clamped to the chunk's sub-cells
  function automatic int cell_of(input longint bound, input longint origin,
                                 input longint step);
    longint d;
    longint q;
    d = bound - origin;
    q = d / step;
    if ((d % step) != 0 && d < 0)
      q = q - 1;
    if (q < 0)
      q = 0;
    if (q > SUBDIV - 1)
      q = SUBDIV - 1;
    return int'(q);
  endfunction

  // Fold one accepted vertex into the box; a closing vertex queues its cells.
  function automatic void predict_bins(input tsb_pkg::in_t v);
    logic signed [COORD_W-1:0] p  [3];
    logic signed [CHUNK_W-1:0] ch [3];
    longint                    step;
    longint                    origin;
    int                        lo [3];
    int                        hi [3];
    int                        a, x, y, z;
    tsb_pkg::out_t             r;
    p[0]  = v.vertex_x;
    p[1]  = v.vertex_y;
    p[2]  = v.vertex_z;
    ch[0] = v.chunk_x;
    ch[1] = v.chunk_y;
    ch[2] = v.chunk_z;
    for (a = 0; a < 3; a++) begin
      if (verts_taken == 0) begin
        box_lo[a] = p[a];
        box_hi[a] = p[a];
      end else begin
        if (p[a] < box_lo[a]) box_lo[a] = p[a];
        if (p[a] > box_hi[a]) box_hi[a] = p[a];
      end
    end
    if (verts_taken < 3)
      verts_taken++;
    if (!v.final_vertex)
      return;

    // size 0 behaves as 1
    step = (cell_size == '0) ? 64'sd1 : longint'(cell_size);
    for (a = 0; a < 3; a++) begin
      origin = longint'(ch[a]) * SUBDIV * step;
      lo[a]  = cell_of(longint'(box_lo[a]), origin, step);
      hi[a]  = cell_of(longint'(box_hi[a]), origin, step);
    end
    // x outermost, z innermost
    for (x = lo[0]; x <= hi[0]; x++)
      for (y = lo[1]; y <= hi[1]; y++)
        for (z = lo[2]; z <= hi[2]; z++) begin
          r.tri_out   = v.triangle_id;
          r.sub_x     = OUT_IDX_W'(x);
          r.sub_y     = OUT_IDX_W'(y);
          r.sub_z     = OUT_IDX_W'(z);
          r.last_cell = (x == hi[0] && y == hi[1] && z == hi[2]);
          pending_cells.insert(pending_cells.size(), r);
        end
    verts_taken = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic tsb_pkg::in_t noise_vertex();
    tsb_pkg::in_t v;
    v.vertex_x     = $urandom;
    v.vertex_y     = $urandom;
    v.vertex_z     = $urandom;
    v.chunk_x      = CHUNK_W'($urandom);
    v.chunk_y      = CHUNK_W'($urandom);
    v.chunk_z      = CHUNK_W'($urandom);
    v.triangle_id  = TRI_W'($urandom);
    v.final_vertex = ($urandom_range(0, 3) == 0);
    return v;
  endfunction

  function automatic tsb_pkg::in_t make_vertex(input int x, input int y, input int z,
                                               input shortint cx, input shortint cy,
                                               input shortint cz,
                                               input logic [TRI_W-1:0] tri_id,
                                               input bit fin);
    tsb_pkg::in_t v;
    v.vertex_x     = x;
    v.vertex_y     = y;
    v.vertex_z     = z;
    v.chunk_x      = cx;
    v.chunk_y      = cy;
    v.chunk_z      = cz;
    v.triangle_id  = tri_id;
    v.final_vertex = fin;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one vertex per call, optional idle burst in front of it.
  // in_valid is left high after the handshake so that back-to-back items
  // never see a low/high pair in the same step.
  // --------------------------------------------------------------------------
  task automatic push_vertex(input tsb_pkg::in_t vtx);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      in_data  <= noise_vertex();   // junk while idle
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= vtx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vertices_sent++;
    predict_bins(vtx);
  endtask

  // A triangle of n_verts vertices scattered around its chunk. Chunk range
  // is limited so that every coordinate still fits in 32 bits.
  task automatic send_triangle(input int n_verts);
    tsb_pkg::in_t              v;
    longint                    step, lim;
    longint                    origin [3];
    longint                    base   [3];
    longint                    span   [3];
    logic signed [CHUNK_W-1:0] ch     [3];
    logic signed [COORD_W-1:0] p      [3];
    int                        a, i;
    step = (cell_size == '0) ? 64'sd1 : longint'(cell_size);
    lim  = 64'sd2147483647 / (SUBDIV * step) - 3;
    if (lim > 32767)
      lim = 32767;
    for (a = 0; a < 3; a++) begin
      ch[a]     = CHUNK_W'(longint'($urandom_range(0, 2 * lim)) - lim);
      origin[a] = longint'(ch[a]) * SUBDIV * step;
      base[a]   = longint'($urandom_range(0, 6 * step)) - step;  // one cell past each side
      span[a]   = longint'($urandom_range(0, 3)) * step;
    end
    for (i = 0; i < n_verts; i++) begin
      v = noise_vertex();     // chunk and id of non-closing vertices stay junk
      for (a = 0; a < 3; a++)
        p[a] = COORD_W'(origin[a] + base[a] + longint'($urandom_range(0, span[a])));
      v.vertex_x     = p[0];
      v.vertex_y     = p[1];
      v.vertex_z     = p[2];
      v.final_vertex = (i == n_verts - 1);
      if (v.final_vertex) begin
        v.chunk_x = ch[0];
        v.chunk_y = ch[1];
        v.chunk_z = ch[2];
      end
      push_vertex(v);
    end
  endtask

  // Stop sending, wait for every owed sub-cell, then let the block settle.
  task automatic wait_bins_done();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_cells.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_cells.size() != 0) begin
      report_mismatch($sformatf("%0d sub-cells never arrived", pending_cells.size()));
      pending_cells.delete();
    end
    repeat (LATENCY_MAX) @(posedge clk);
  endtask

  // APB write of sub_cell_size, then read it back. Upper data bits are junk.
  task automatic write_cell_size(input logic [SIZE_W-1:0] size);
    logic [CFG_DW-1:0] wdata;
    wdata             = $urandom;
    wdata[SIZE_W-1:0] = size;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= tsb_pkg::ADDR_SUB_CELL_SIZE;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cell_size = size;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[SIZE_W-1:0] !== size)
      report_mismatch($sformatf("sub_cell_size reads %h, wrote %h",
                                cfg_prdata[SIZE_W-1:0], size));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, then the field-by-field check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);   // start a stall burst of random length
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_cells
    tsb_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("sub-cell with nothing pending: tri %h cell %0d,%0d,%0d",
                                  out_data.tri_out, out_data.sub_x, out_data.sub_y,
                                  out_data.sub_z));
      end else begin
        want = pending_cells.pop_front();
        if (out_data.tri_out !== want.tri_out)
          report_mismatch($sformatf("tri_out %h, want %h", out_data.tri_out, want.tri_out));
        if (out_data.sub_x !== want.sub_x)
          report_mismatch($sformatf("tri %h sub_x %0d, want %0d", want.tri_out,
                                    out_data.sub_x, want.sub_x));
        if (out_data.sub_y !== want.sub_y)
          report_mismatch($sformatf("tri %h sub_y %0d, want %0d", want.tri_out,
                                    out_data.sub_y, want.sub_y));
        if (out_data.sub_z !== want.sub_z)
          report_mismatch($sformatf("tri %h sub_z %0d, want %0d", want.tri_out,
                                    out_data.sub_z, want.sub_z));
        if (out_data.last_cell !== want.last_cell)
          report_mismatch($sformatf("tri %h cell %0d,%0d,%0d last_cell %b, want %b",
                                    want.tri_out, want.sub_x, want.sub_y, want.sub_z,
                                    out_data.last_cell, want.last_cell));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Default size 1.5: one triangle over the whole chunk (64 cells),
  // one inside a single cell of an offset chunk.
  task automatic test_chunk_span();
    push_vertex(make_vertex(0, 0, 0, 0, 0, 0, 16'h1234, 1'b0));
    push_vertex(make_vertex(1535, 1535, 1535, 0, 0, 0, 16'h1234, 1'b0));
    push_vertex(make_vertex(700, 20, 1500, 0, 0, 0, 16'hFFFF, 1'b1));
    // chunk (-1, 2, 0): origin (-1536, 3072, 0), all vertices in cell (1,1,1)
    push_vertex(make_vertex(-1100, 3472, 450, 0, 0, 0, 16'h0000, 1'b0));
    push_vertex(make_vertex(-1000, 3572, 700, 0, 0, 0, 16'h0000, 1'b0));
    push_vertex(make_vertex(-1136, 3839, 384, -1, 2, 0, 16'h0000, 1'b1));
    wait_bins_done();
  endtask

  // Triangles closed after one, two and five vertices.
  task automatic test_short_long();
    push_vertex(make_vertex(100, 900, 1400, 0, 0, 0, 16'h0001, 1'b1));
    push_vertex(make_vertex(10, 10, 10, 3, -3, 7, 16'h5555, 1'b0));
    push_vertex(make_vertex(1000, 400, 20, 0, 0, 0, 16'h0002, 1'b1));
    push_vertex(make_vertex(200, 200, 200, 0, 0, 0, 16'hAAAA, 1'b0));
    push_vertex(make_vertex(1200, 300, 100, 0, 0, 0, 16'hAAAA, 1'b0));
    push_vertex(make_vertex(50, 1300, 900, 0, 0, 0, 16'hAAAA, 1'b0));
    push_vertex(make_vertex(800, 800, 1530, 0, 0, 0, 16'hAAAA, 1'b0));
    push_vertex(make_vertex(600, 100, -50, 0, 0, 0, 16'h0003, 1'b1));  // vertex count saturated
    wait_bins_done();
  endtask

  // Bounds far outside the chunk clamp to the edge cells; negative
  // offsets round toward minus infinity.
  task automatic test_far_bounds();
    push_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32767, 32767, 32767, 16'hFFFF, 1'b1));
    push_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            -32768, -32768, -32768, 16'h0000, 1'b1));
    push_vertex(make_vertex(-1, -1, -1, 0, 0, 0, 16'h7FFF, 1'b0));
    push_vertex(make_vertex(384, 767, 1152, 0, 0, 0, 16'h8000, 1'b1));
    wait_bins_done();
  endtask

  // Size 0 (acts as 1) and the largest size; the size only changes
  // once the block has gone quiet.
  task automatic test_size_extremes();
    write_cell_size(16'd0);
    send_triangle(3);
    wait_bins_done();
    write_cell_size(16'hFFFF);
    send_triangle(3);
    wait_bins_done();
  endtask

  // Mostly well-formed triangles, some short/long ones and some junk items.
  task automatic test_random_mix(input logic [SIZE_W-1:0] size, input int n_items,
                                 input bit with_idle);
    int start;
    int pick;
    idle_on = with_idle;
    write_cell_size(size);
    start = vertices_sent;
    while (vertices_sent - start < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 2)
        push_vertex(noise_vertex());
      else if (pick < 16)
        send_triangle(3);
      else if (pick == 16)
        send_triangle(1);
      else if (pick == 17)
        send_triangle(2);
      else
        send_triangle($urandom_range(4, 6));
    end
    wait_bins_done();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_chunk_span();
    test_short_long();
    test_far_bounds();
    test_size_extremes();

    test_random_mix(16'd1, 35, 1'b1);
    test_random_mix(SIZE_W'($urandom_range(2, 64)), 35, 1'b1);
    test_random_mix(SIZE_W'($urandom_range(65, 65534)), 35, 1'b1);
    test_random_mix(16'hFFFF, 35, 1'b1);
    test_random_mix(tsb_pkg::SUB_CELL_SIZE_RST, 35, 1'b1);
    test_random_mix(SIZE_W'($urandom_range(1, 2048)), 25, 1'b0);   // full rate at the end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #(3_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
sv/tsb_pkg.sv
sv/tsb_alu.sv
sv/triangle_subcell_binning.sv
tb/triangle_subcell_binning_tb.sv
